// ===== sv/mhpq_pkg.sv =====
// Shared types, sizes and codes for the min-heap priority queue.
package mhpq_pkg;

   localparam int CAPACITY      = 256;
   localparam int KEY_WIDTH     = 32;
   localparam int PAYLOAD_WIDTH = 16;

   localparam int ADDR_W  = $clog2(CAPACITY);
   localparam int COUNT_W = $clog2(CAPACITY + 1);
   // Child index 2*pos+2 can reach 2*CAPACITY and needs two bits beyond the address.
   localparam int IDX_W   = ADDR_W + 2;

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [IDX_W-1:0]   idx_type;

   typedef struct packed {
      logic [KEY_WIDTH-1:0]     key;
      logic [PAYLOAD_WIDTH-1:0] payload;
   } entry_type;

   typedef struct packed {
      logic      en;
      addr_type  addr;
      entry_type data;
   } ram_wr_type;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_WAIT,
      ST_UP_CMP,
      ST_DN_CMP,
      ST_PLACE,
      ST_DONE
   } state_type;

endpackage

// ===== sv/mhpq_if.sv =====
// Request and response channel interfaces of the min-heap priority queue.
interface mhpq_req_if import mhpq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic [KEY_WIDTH-1:0]     item_key;
   logic [PAYLOAD_WIDTH-1:0] item_payload;

   modport source (output valid, output req_type, output item_key, output item_payload,
                   input ready);
   modport sink   (input valid, input req_type, input item_key, input item_payload,
                   output ready);
endinterface

interface mhpq_rsp_if import mhpq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   status_type               status;
   logic [KEY_WIDTH-1:0]     out_key;
   logic [PAYLOAD_WIDTH-1:0] out_payload;
   logic [COUNT_W-1:0]       count_after;

   modport source (output valid, output status, output out_key, output out_payload,
                   output count_after, input ready);
   modport sink   (input valid, input status, input out_key, input out_payload,
                   input count_after, output ready);
endinterface

// ===== sv/min_heap_priority_queue_unit.sv =====
// Top level of the binary min-heap priority queue with its sift sequencer.
//
//   channel   direction  handshake            item contents
//   req_chan  in         valid/ready          req_type, item_key, item_payload
//   rsp_chan  out        valid/ready          status, out_key, out_payload, count_after
//
// Each item is handled on its own, from its accepting cycle until its result appears
// on rsp_chan. A push onto an empty heap steps through accept, place and register
// the result. Any other push adds one compare step per heap level visited (1 to 8)
// between accept and place. A pop adds a step to fetch root and tail, then one
// compare step per level visited (1 to 8). The pop that empties the heap skips the
// sift. Pops on an empty heap and pushes on a full heap go straight from accept to
// registering the result. The sequence is set by the single read-compare-write pass
// per level through the entry memory, whose reads are registered.
// Reset is synchronous and clears the entry count and control state; the entry
// memory itself is not cleared, since only entries below the count are ever read.
// A new item is accepted whenever the sequencer is idle, even while the previous
// result still waits on rsp_chan; a finished item waits in the done state until
// the output register is free.
module min_heap_priority_queue_unit import mhpq_pkg::*; (
   input logic          clock,
   input logic          reset,
   mhpq_req_if.sink     req_chan,
   mhpq_rsp_if.source   rsp_chan
);

   // Sequencer state and working registers.
   state_type  state_ff, state_in;
   count_type  count_ff, count_in;
   addr_type   pos_ff, pos_in;
   entry_type  cur_ff, cur_in;

   // Result of the item in flight, held until the output register is free.
   status_type               res_status_ff, res_status_in;
   logic [KEY_WIDTH-1:0]     res_key_ff, res_key_in;
   logic [PAYLOAD_WIDTH-1:0] res_pay_ff, res_pay_in;

   // Output register.
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [KEY_WIDTH-1:0]     rsp_key_ff, rsp_key_in;
   logic [PAYLOAD_WIDTH-1:0] rsp_pay_ff, rsp_pay_in;
   count_type                rsp_count_ff, rsp_count_in;

   // Memory ports.
   ram_wr_type ram_wr;
   addr_type   rd_addr_a;
   addr_type   rd_addr_b;
   entry_type  rd_data_a;
   entry_type  rd_data_b;

   // Compare network.
   logic      req_accept;
   logic      rsp_free;
   logic      is_pop;
   addr_type  up_addr;
   addr_type  up_up_addr;
   logic      up_swap;
   idx_type   l_idx;
   idx_type   r_idx;
   logic      l_ok;
   logic      r_ok;
   logic      pick_r;
   entry_type pick_e;
   addr_type  pick_addr;
   idx_type   pick_l_idx;
   logic      dn_swap;

   mhpq_ram u_ram (
      .clock     (clock),
      .wr        (ram_wr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign is_pop         = (req_chan.req_type == OP_POP);
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // Sift-up: the parent of the hole and, for the next level, its own parent.
   assign up_addr    = (pos_ff - addr_type'(1)) >> 1;
   assign up_up_addr = (up_addr - addr_type'(1)) >> 1;
   // The parent key arrives on port A; a strictly greater parent moves down.
   assign up_swap    = rd_data_a.key > cur_ff.key;

   // Sift-down: children of the hole arrive on ports A (left) and B (right).
   assign l_idx  = {1'b0, pos_ff, 1'b1};
   assign r_idx  = l_idx + idx_type'(1);
   assign l_ok   = l_idx < idx_type'(count_ff);
   assign r_ok   = r_idx < idx_type'(count_ff);
   // The right child wins only when it exists and is strictly smaller.
   assign pick_r = r_ok && (rd_data_b.key < rd_data_a.key);
   assign pick_e = pick_r ? rd_data_b : rd_data_a;
   assign pick_addr  = pick_r ? addr_type'(r_idx) : addr_type'(l_idx);
   assign pick_l_idx = {1'b0, pick_addr, 1'b1};
   // Equal keys never swap.
   assign dn_swap = l_ok && (cur_ff.key > pick_e.key);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (is_pop) begin
                  state_in = (count_ff == '0) ? ST_DONE : ST_POP_WAIT;
               end else if (count_ff == count_type'(CAPACITY)) begin
                  state_in = ST_DONE;
               end else if (count_ff == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  state_in = ST_UP_CMP;
               end
            end
         end
         ST_POP_WAIT: begin
            state_in = (count_ff == '0) ? ST_DONE : ST_DN_CMP;
         end
         ST_UP_CMP: begin
            state_in = (up_swap && up_addr != '0) ? ST_UP_CMP : ST_PLACE;
         end
         ST_DN_CMP: begin
            state_in = dn_swap ? ST_DN_CMP : ST_PLACE;
         end
         ST_PLACE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = rsp_free ? ST_IDLE : ST_DONE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and memory control. The moving entry stays in cur_ff as a hole walks
   // through the heap; each level writes only the entry that moves into the hole,
   // and the next read addresses never equal the address written in that cycle.
   always_comb begin
      count_in      = count_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_pay_in    = res_pay_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_count_in  = rsp_count_ff;
      ram_wr        = '0;
      rd_addr_a     = '0;
      rd_addr_b     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               res_key_in = '0;
               res_pay_in = '0;
               if (is_pop) begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                  end else begin
                     // Fetch the root and the tail together.
                     res_status_in = STATUS_OK;
                     count_in      = count_ff - count_type'(1);
                     rd_addr_a     = '0;
                     rd_addr_b     = addr_type'(count_ff - count_type'(1));
                  end
               end else begin
                  if (count_ff == count_type'(CAPACITY)) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     res_status_in = STATUS_OK;
                     cur_in.key    = req_chan.item_key;
                     cur_in.payload = req_chan.item_payload;
                     pos_in        = addr_type'(count_ff);
                     count_in      = count_ff + count_type'(1);
                     rd_addr_a     = addr_type'((count_ff - count_type'(1)) >> 1);
                  end
               end
            end
         end
         ST_POP_WAIT: begin
            res_key_in = rd_data_a.key;
            res_pay_in = rd_data_a.payload;
            cur_in     = rd_data_b;
            pos_in     = '0;
            rd_addr_a  = addr_type'(1);
            rd_addr_b  = addr_type'(2);
         end
         ST_UP_CMP: begin
            if (up_swap) begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = pos_ff;
               ram_wr.data = rd_data_a;
               pos_in      = up_addr;
               rd_addr_a   = up_up_addr;
            end
         end
         ST_DN_CMP: begin
            if (dn_swap) begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = pos_ff;
               ram_wr.data = pick_e;
               pos_in      = pick_addr;
               rd_addr_a   = addr_type'(pick_l_idx);
               rd_addr_b   = addr_type'(pick_l_idx + idx_type'(1));
            end
         end
         ST_PLACE: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = pos_ff;
            ram_wr.data = cur_ff;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_key_in    = res_key_ff;
               rsp_pay_in    = res_pay_ff;
               rsp_count_in  = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_pay_ff    <= res_pay_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.out_key     = rsp_key_ff;
   assign rsp_chan.out_payload = rsp_pay_ff;
   assign rsp_chan.count_after = rsp_count_ff;

   // The entry count never runs past the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(CAPACITY))
      else $error("entry count above capacity");

   // A full report always comes with a full heap.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == STATUS_FULL)
      |-> rsp_chan.count_after == count_type'(CAPACITY))
      else $error("full status with heap not full");

   // An empty report comes with an empty heap and zero data.
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == STATUS_EMPTY)
      |-> (rsp_chan.count_after == '0 && rsp_chan.out_key == '0
           && rsp_chan.out_payload == '0))
      else $error("empty status with nonzero count or data");

   // The memory is never written while the sequencer is idle or waiting to report.
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DONE) |-> !ram_wr.en)
      else $error("entry write outside a sift");

   // The sift-down hole always lies inside the live part of the heap.
   a_hole_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DN_CMP) |-> idx_type'(pos_ff) < idx_type'(count_ff))
      else $error("sift-down position beyond entry count");

endmodule

// ===== sv/mhpq_ram.sv =====
// Heap entry storage: one write port, two registered read ports.
module mhpq_ram import mhpq_pkg::*; (
   input  logic       clock,
   input  ram_wr_type wr,
   input  addr_type   rd_addr_a,
   input  addr_type   rd_addr_b,
   output entry_type  rd_data_a,
   output entry_type  rd_data_b
);

   entry_type mem_ff [CAPACITY];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
